@@ rtl/cau_pkg.sv @@
// Shared types, operation and status codes, and the saturation helper
// for the complex arithmetic unit. No dependencies.
package cau_pkg;

  localparam int WORD_W = 32;
  localparam int NSTEP  = 34;  // division check plus 33 quotient bits

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;
  localparam logic [2:0] OP_ARG  = 3'd6;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] v;
    logic              sat;
  } fin_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [WORD_W-1:0] ar;
    logic [WORD_W-1:0] ai;
    logic [WORD_W-1:0] br;
    logic [WORD_W-1:0] bi;
    logic [WORD_W-1:0] sre;
    logic [WORD_W-1:0] sim;
    logic              ssat;
  } item_t;

  // Clamp a sign-magnitude value to the signed word range.
  function automatic fin_t sat_fin(input logic neg, input logic [65:0] m);
    fin_t f;
    f.sat = 1'b0;
    if (!neg) begin
      if (m > 66'h7FFF_FFFF) begin
        f.sat = 1'b1;
        f.v   = 32'h7FFF_FFFF;
      end else begin
        f.v = m[31:0];
      end
    end else begin
      if (m > 66'h8000_0000) begin
        f.sat = 1'b1;
        f.v   = 32'h8000_0000;
      end else begin
        f.v = 32'(-m[31:0]);
      end
    end
    return f;
  endfunction

endpackage

@@ rtl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit in signed Q16.16: add, subtract, multiply, divide,
// conjugate, modulus and argument. One item is taken per clock while busy is
// low; the result strobe out_valid is high for one cycle per result, in order,
// and must be caught while it is high, since results cannot be held off. The
// divider resolves one quotient bit per stage over 33 stages plus an overflow
// check; the square root and the 16-step angle CORDIC run alongside it. busy
// is high while reset is asserted and otherwise rises only if the item queue
// fills.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_a_real,
  input  logic [31:0] in_a_imag,
  input  logic [31:0] in_b_real,
  input  logic [31:0] in_b_imag,
  output logic        out_valid,
  output logic [31:0] out_res_real,
  output logic [31:0] out_res_imag,
  output logic [1:0]  out_status
);

  cau_pkg::item_t f_item, q_item;
  logic           push, q_empty, q_full;

  // Refuse items while reset is held or the queue is full
  assign busy = q_full || !rst_n;

  cau_front u_front (
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_a_real    (in_a_real),
    .in_a_imag    (in_a_imag),
    .in_b_real    (in_b_real),
    .in_b_imag    (in_b_imag),
    .push         (push),
    .item         (f_item)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (!q_empty),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  cau_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (!q_empty),
    .in_item      (q_item),
    .out_valid    (out_valid),
    .out_res_real (out_res_real),
    .out_res_imag (out_res_imag),
    .out_status   (out_status)
  );

endmodule

@@ rtl/cau_front.sv @@
// Front end of the complex arithmetic unit: accepts items, classifies the
// operation and settles the add, subtract and conjugate results.
// Depends on cau_pkg.
module cau_front (
  input  logic                start,
  input  logic                busy,
  input  logic [2:0]          in_operation,
  input  logic [31:0]         in_a_real,
  input  logic [31:0]         in_a_imag,
  input  logic [31:0]         in_b_real,
  input  logic [31:0]         in_b_imag,
  output logic                push,
  output cau_pkg::item_t      item
);

  logic [32:0]   sum_re, sum_im, mag_re, mag_im, ai_mag;
  cau_pkg::fin_t f_re, f_im;
  logic          sub, ai_pos;

  assign push = start && !busy;
  assign sub  = (in_operation == cau_pkg::OP_SUB);

  always_comb begin
    sum_re = sub ? 33'({in_a_real[31], in_a_real} - {in_b_real[31], in_b_real})
                 : 33'({in_a_real[31], in_a_real} + {in_b_real[31], in_b_real});
    sum_im = sub ? 33'({in_a_imag[31], in_a_imag} - {in_b_imag[31], in_b_imag})
                 : 33'({in_a_imag[31], in_a_imag} + {in_b_imag[31], in_b_imag});
    mag_re = sum_re[32] ? 33'(-sum_re) : sum_re;
    mag_im = sum_im[32] ? 33'(-sum_im) : sum_im;
    ai_pos = !in_a_imag[31] && (in_a_imag != '0);
    ai_mag = in_a_imag[31] ? 33'(-{in_a_imag[31], in_a_imag}) : {1'b0, in_a_imag};

    item.op = in_operation;
    item.ar = in_a_real;
    item.ai = in_a_imag;
    item.br = in_b_real;
    item.bi = in_b_imag;

    unique case (in_operation)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        f_re = cau_pkg::sat_fin(sum_re[32], {33'b0, mag_re});
        f_im = cau_pkg::sat_fin(sum_im[32], {33'b0, mag_im});
      end
      cau_pkg::OP_CONJ: begin
        f_re = '{v: in_a_real, sat: 1'b0};
        f_im = cau_pkg::sat_fin(ai_pos, {33'b0, ai_mag});
      end
      default: begin
        f_re = '0;
        f_im = '0;
      end
    endcase
    item.sre  = f_re.v;
    item.sim  = f_im.v;
    item.ssat = f_re.sat || f_im.sat;
  end

endmodule

@@ rtl/cau_queue.sv @@
// Two-entry item queue between the front and back ends.
// Depends on cau_pkg.
module cau_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cau_pkg::item_t wr_item,
  input  logic           pop,
  output cau_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);

  cau_pkg::item_t mem [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && !empty)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop && !empty) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_item;
  end

endmodule

@@ rtl/cau_back.sv @@
// Back end of the complex arithmetic unit: products, a bit-per-stage
// divider, a digit-per-stage square root and an angle CORDIC in lockstep.
// Depends on cau_pkg.
module cau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  cau_pkg::item_t in_item,
  output logic           out_valid,
  output logic [31:0]    out_res_real,
  output logic [31:0]    out_res_imag,
  output logic [1:0]     out_status
);

  typedef struct packed {
    logic        neg;
    logic [63:0] n;
    logic [63:0] r;
    logic [32:0] q;
    logic        ov;
  } lane_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] sre;
    logic [31:0] sim;
    logic        ssat;
    logic [63:0] p0, p1, p2, p3, p4, p5;
    logic [59:0] cx, cy;
    logic [35:0] cz;
    logic        czero;
  } a_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        dz;
    logic [31:0] sre;
    logic [31:0] sim;
    logic        ssat;
    logic [63:0] den;
    lane_t       lt;
    lane_t       lu;
    logic [33:0] srem;
    logic [31:0] sroot;
    logic [59:0] cx, cy;
    logic [35:0] cz;
    logic        czero;
  } stg_t;

  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic [21:0]        ARG_FULL   = 22'd411775;

  function automatic logic [35:0] atan_q30(input int i);
    logic [35:0] v;
    unique case (i)
      0:  v = 36'h03243F6A8;
      1:  v = 36'h01DAC6705;
      2:  v = 36'h00FADBAFC;
      3:  v = 36'h007F56EA6;
      4:  v = 36'h003FEAB76;
      5:  v = 36'h001FFD55B;
      6:  v = 36'h000FFFAAA;
      7:  v = 36'h0007FFF55;
      8:  v = 36'h0003FFFEA;
      9:  v = 36'h0001FFFFD;
      10: v = 36'h0000FFFFF;
      11: v = 36'h00007FFFF;
      12: v = 36'h00003FFFF;
      13: v = 36'h00001FFFF;
      14: v = 36'h00000FFFF;
      default: v = 36'h000007FFF;
    endcase
    return v;
  endfunction

  // One quotient bit at position j of (n << 16) / den.
  function automatic lane_t div_step(input lane_t l, input logic [63:0] den, input int j);
    lane_t       o;
    logic [79:0] nsh;
    logic [64:0] rs;
    o   = l;
    nsh = {l.n, 16'b0};
    rs  = {l.r, nsh[j]};
    if (rs >= {1'b0, den}) begin
      o.r    = 64'(rs - {1'b0, den});
      o.q[j] = 1'b1;
    end else begin
      o.r = rs[63:0];
    end
    return o;
  endfunction

  function automatic cau_pkg::fin_t div_fin(input lane_t l, input logic [63:0] den);
    logic        big, rnd;
    logic [65:0] m;
    big = l.ov || l.q[32] || (l.q[31] && (l.q[30:0] != '0));
    rnd = ({l.r, 1'b0} >= {1'b0, den});
    m   = big ? '1 : 66'(l.q) + 66'(rnd);
    return cau_pkg::sat_fin(l.neg, m);
  endfunction

  a_t   a_r, a_nxt;
  stg_t stg_r   [0:cau_pkg::NSTEP];
  stg_t stg_nxt [0:cau_pkg::NSTEP];
  logic [cau_pkg::NSTEP:0] vld_r;
  logic a_vld_r;

  logic [31:0] res_re_nxt, res_im_nxt, res_re_r, res_im_r;
  logic [1:0]  st_nxt, st_r;
  logic        out_vld_r;

  // Stage A: products and CORDIC prerotation
  always_comb begin
    logic signed [31:0] x, y;
    logic signed [59:0] cx0, cy0;
    x = (in_item.op == cau_pkg::OP_MOD) ? $signed(in_item.ar) : $signed(in_item.br);
    y = (in_item.op == cau_pkg::OP_MOD) ? $signed(in_item.ai) : $signed(in_item.bi);
    a_nxt.op   = in_item.op;
    a_nxt.sre  = in_item.sre;
    a_nxt.sim  = in_item.sim;
    a_nxt.ssat = in_item.ssat;
    a_nxt.p0   = 64'($signed(in_item.ar) * $signed(in_item.br));
    a_nxt.p1   = 64'($signed(in_item.ai) * $signed(in_item.bi));
    a_nxt.p2   = 64'($signed(in_item.ar) * $signed(in_item.bi));
    a_nxt.p3   = 64'($signed(in_item.ai) * $signed(in_item.br));
    a_nxt.p4   = 64'(x * x);
    a_nxt.p5   = 64'(y * y);
    cx0 = $signed({{4{in_item.ar[31]}}, in_item.ar, 24'b0});
    cy0 = $signed({{4{in_item.ai[31]}}, in_item.ai, 24'b0});
    a_nxt.czero = (in_item.ar == '0) && (in_item.ai == '0);
    if (in_item.ar[31]) begin
      a_nxt.cx = 60'(-cx0);
      a_nxt.cy = 60'(-cy0);
      a_nxt.cz = PI_Q30;
    end else begin
      a_nxt.cx = cx0;
      a_nxt.cy = cy0;
      a_nxt.cz = '0;
    end
  end

  // Stage B: combine products, set up divider and square root
  always_comb begin
    logic signed [64:0] tm, um, td, ud;
    logic [63:0]        mt, mu;
    logic [65:0]        rt, ru;
    cau_pkg::fin_t      ft, fu;
    tm = $signed({a_r.p0[63], a_r.p0}) - $signed({a_r.p1[63], a_r.p1});
    um = $signed({a_r.p2[63], a_r.p2}) + $signed({a_r.p3[63], a_r.p3});
    td = $signed({a_r.p0[63], a_r.p0}) + $signed({a_r.p1[63], a_r.p1});
    ud = $signed({a_r.p3[63], a_r.p3}) - $signed({a_r.p2[63], a_r.p2});
    mt = tm[64] ? 64'(-tm) : tm[63:0];
    mu = um[64] ? 64'(-um) : um[63:0];
    rt = ({2'b0, mt} + 66'h8000) >> 16;
    ru = ({2'b0, mu} + 66'h8000) >> 16;
    ft = cau_pkg::sat_fin(tm[64], rt);
    fu = cau_pkg::sat_fin(um[64], ru);

    stg_nxt[0].op  = a_r.op;
    stg_nxt[0].den = a_r.p4 + a_r.p5;
    stg_nxt[0].dz  = (a_r.p4 + a_r.p5) == '0;
    if (a_r.op == cau_pkg::OP_MUL) begin
      stg_nxt[0].sre  = ft.v;
      stg_nxt[0].sim  = fu.v;
      stg_nxt[0].ssat = ft.sat || fu.sat;
    end else begin
      stg_nxt[0].sre  = a_r.sre;
      stg_nxt[0].sim  = a_r.sim;
      stg_nxt[0].ssat = a_r.ssat;
    end
    stg_nxt[0].lt.neg = td[64];
    stg_nxt[0].lt.n   = td[64] ? 64'(-td) : td[63:0];
    stg_nxt[0].lt.r   = stg_nxt[0].lt.n >> 17;
    stg_nxt[0].lt.q   = '0;
    stg_nxt[0].lt.ov  = 1'b0;
    stg_nxt[0].lu.neg = ud[64];
    stg_nxt[0].lu.n   = ud[64] ? 64'(-ud) : ud[63:0];
    stg_nxt[0].lu.r   = stg_nxt[0].lu.n >> 17;
    stg_nxt[0].lu.q   = '0;
    stg_nxt[0].lu.ov  = 1'b0;
    stg_nxt[0].srem   = '0;
    stg_nxt[0].sroot  = '0;
    stg_nxt[0].cx     = a_r.cx;
    stg_nxt[0].cy     = a_r.cy;
    stg_nxt[0].cz     = a_r.cz;
    stg_nxt[0].czero  = a_r.czero;
  end

  // Step stages: divider check or bit; leading stages add root and CORDIC
  for (genvar k = 0; k < cau_pkg::NSTEP; k++) begin : g_step
    always_comb begin
      stg_t               s;
      logic [35:0]        rem, trial;
      logic signed [59:0] x, y, dx, dy;
      logic signed [35:0] z;
      s = stg_r[k];
      if (k == 0) begin
        s.lt.ov = ({17'b0, stg_r[k].lt.n[63:17]} >= stg_r[k].den);
        s.lu.ov = ({17'b0, stg_r[k].lu.n[63:17]} >= stg_r[k].den);
      end else begin
        s.lt = div_step(stg_r[k].lt, stg_r[k].den, 33 - k);
        s.lu = div_step(stg_r[k].lu, stg_r[k].den, 33 - k);
      end
      rem   = {stg_r[k].srem, stg_r[k].den[2 * ((31 - k) & 31) +: 2]};
      trial = {2'b0, stg_r[k].sroot, 2'b01};
      if (k < 32) begin
        if (rem >= trial) begin
          s.srem  = 34'(rem - trial);
          s.sroot = {stg_r[k].sroot[30:0], 1'b1};
        end else begin
          s.srem  = rem[33:0];
          s.sroot = {stg_r[k].sroot[30:0], 1'b0};
        end
      end
      x  = $signed(stg_r[k].cx);
      y  = $signed(stg_r[k].cy);
      z  = $signed(stg_r[k].cz);
      dx = y >>> (k & 15);
      dy = x >>> (k & 15);
      if (k < 16) begin
        if (y > 60'sd0) begin
          s.cx = 60'(x + dx);
          s.cy = 60'(y - dy);
          s.cz = 36'(z + $signed(atan_q30(k)));
        end else begin
          s.cx = 60'(x - dx);
          s.cy = 60'(y + dy);
          s.cz = 36'(z - $signed(atan_q30(k)));
        end
      end
      stg_nxt[k + 1] = s;
    end
  end

  // Final stage: pick the result for the operation
  always_comb begin
    stg_t               s;
    cau_pkg::fin_t      ft, fu, fm;
    logic signed [35:0] z;
    logic [35:0]        zr;
    logic [21:0]        u;
    logic [32:0]        root;
    logic               sat;
    s    = stg_r[cau_pkg::NSTEP];
    ft   = div_fin(s.lt, s.den);
    fu   = div_fin(s.lu, s.den);
    root = {1'b0, s.sroot} + 33'({2'b0, s.sroot} < s.srem);
    fm   = cau_pkg::sat_fin(1'b0, {33'b0, root});
    z    = $signed(s.cz);
    if (z < 36'sd0) z = 36'(z + TWO_PI_Q30);
    if (z < 36'sd0) z = '0;
    zr = 36'(z) + 36'h2000;
    u  = zr[35:14];
    if (u >= ARG_FULL || s.czero) u = '0;
    res_re_nxt = '0;
    res_im_nxt = '0;
    sat        = 1'b0;
    st_nxt     = cau_pkg::ST_OK;
    unique case (s.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_CONJ: begin
        res_re_nxt = s.sre;
        res_im_nxt = s.sim;
        sat        = s.ssat;
      end
      cau_pkg::OP_DIV: begin
        if (s.dz) begin
          st_nxt = cau_pkg::ST_DZ;
        end else begin
          res_re_nxt = ft.v;
          res_im_nxt = fu.v;
          sat        = ft.sat || fu.sat;
        end
      end
      cau_pkg::OP_MOD: begin
        res_re_nxt = fm.v;
        sat        = fm.sat;
      end
      cau_pkg::OP_ARG: res_re_nxt = {10'b0, u};
      default: ;
    endcase
    if (sat && st_nxt == cau_pkg::ST_OK) st_nxt = cau_pkg::ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= in_valid;
      vld_r     <= {vld_r[cau_pkg::NSTEP-1:0], a_vld_r};
      out_vld_r <= vld_r[cau_pkg::NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    stg_r    <= stg_nxt;
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    st_r     <= st_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_res_real = res_re_r;
  assign out_res_imag = res_im_r;
  assign out_status   = st_r;

endmodule

@@ tb/complex_arithmetic_unit_top_tb.sv @@
// Self-checking bench for complex_arithmetic_unit_top: drives operand items,
// predicts every result in a bit-exact model and checks the strobed results.
// Depends on cau_pkg and the unit itself.
module complex_arithmetic_unit_top_tb;

  localparam logic [2:0] OP_SPARE  = 3'd7;
  localparam int         N_RANDOM  = 1780;
  localparam int         IDLE_LIM  = 3000;
  localparam longint     PI_Q30    = 64'd3373259426;
  localparam longint     TWOPI_Q30 = 64'd6746518852;
  localparam longint     PRESCALE  = 64'd16777216;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ar, ai, br, bi;
    bit          drain;
  } op_item_t;

  typedef struct {
    logic [31:0] rr, ri;
    logic [1:0]  st;
  } cplx_res_t;

  typedef struct {
    bit           neg;
    logic [127:0] m;
  } smag_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic        out_valid;
  logic [31:0] out_res_real, out_res_imag;
  logic [1:0]  out_status;

  op_item_t  pending[$];
  cplx_res_t awaited[$];
  bit        taken = 1'b0;
  int        n_sent = 0, n_checked = 0, n_errors = 0, idle_cycles = 0;
  int        op_count[8];
  int        sat_seen = 0, dz_seen = 0;

  const longint atan_q30[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF};

  complex_arithmetic_unit_top dut (.*);

  always #6 clk = ~clk;

  function automatic smag_t mag_mul(longint a, longint b);
    smag_t r;
    logic [127:0] pa, pb;
    pa = a < 0 ? 128'(-a) : 128'(a);
    pb = b < 0 ? 128'(-b) : 128'(b);
    r.m = pa * pb;
    r.neg = (a < 0) != (b < 0) && r.m != 0;
    return r;
  endfunction

  function automatic smag_t mag_add(smag_t p, smag_t q);
    smag_t r;
    if (p.neg == q.neg) begin
      r.neg = p.neg; r.m = p.m + q.m;
    end else if (p.m >= q.m) begin
      r.neg = p.neg; r.m = p.m - q.m;
    end else begin
      r.neg = q.neg; r.m = q.m - p.m;
    end
    if (r.m == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic smag_t mag_neg(smag_t p);
    if (p.m != 0) p.neg = !p.neg;
    return p;
  endfunction

  function automatic smag_t of_long(longint v);
    smag_t r;
    r.neg = v < 0;
    r.m = v < 0 ? 128'(-v) : 128'(v);
    return r;
  endfunction

  // Clamp to the signed 32-bit range, flag saturation.
  function automatic logic [31:0] clamp32(smag_t s, inout bit sat);
    logic [127:0] lim;
    lim = 128'h8000_0000;
    if (!s.neg) begin
      if (s.m > lim - 1) begin sat = 1'b1; s.m = lim - 1; end
      return s.m[31:0];
    end
    if (s.m > lim) begin sat = 1'b1; s.m = lim; end
    return 32'(-s.m[31:0]);
  endfunction

  function automatic logic [127:0] round_shr(logic [127:0] m, int s);
    return (m + (128'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [127:0] quot_mag(logic [127:0] num, logic [127:0] den);
    logic [127:0] q, r;
    q = num / den;
    r = num % den;
    if (q > 128'h8000_0000) return '1;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin r = r - den; q[0] = 1'b1; end
      if (q > 128'h8000_0000) return '1;
    end
    if ((r << 1) >= den) q = q + 1;
    return q;
  endfunction

  function automatic logic [127:0] sqrt_rnd(logic [127:0] s);
    logic [127:0] r, b;
    r = 0;
    b = 128'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin s = s - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  // Vectoring CORDIC, angle in Q30 folded to [0, 2*pi), then rounded to Q16.
  function automatic logic [127:0] angle_q16(longint re, longint im);
    longint x, y, z, dx, dy;
    logic [127:0] u, full;
    if (re == 0 && im == 0) return 0;
    x = re * PRESCALE;
    y = im * PRESCALE;
    z = 0;
    if (x < 0) begin x = -x; y = -y; z = PI_Q30; end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin x += dx; y -= dy; z += atan_q30[i]; end
      else begin x -= dx; y += dy; z -= atan_q30[i]; end
    end
    if (z < 0) z += TWOPI_Q30;
    if (z < 0) z = 0;
    u = round_shr(128'(z), 14);
    full = round_shr(128'(TWOPI_Q30), 14);
    if (u >= full) u = 0;
    return u;
  endfunction

  function automatic cplx_res_t predict_result(op_item_t it);
    cplx_res_t r;
    longint ar, ai, br, bi;
    smag_t t, u;
    logic [127:0] den;
    bit sat, dz;
    ar = longint'(signed'(it.ar)); ai = longint'(signed'(it.ai));
    br = longint'(signed'(it.br)); bi = longint'(signed'(it.bi));
    sat = 1'b0; dz = 1'b0;
    r.rr = '0; r.ri = '0;
    case (it.op)
      cau_pkg::OP_ADD: begin
        r.rr = clamp32(of_long(ar + br), sat);
        r.ri = clamp32(of_long(ai + bi), sat);
      end
      cau_pkg::OP_SUB: begin
        r.rr = clamp32(of_long(ar - br), sat);
        r.ri = clamp32(of_long(ai - bi), sat);
      end
      cau_pkg::OP_MUL: begin
        t = mag_add(mag_mul(ar, br), mag_neg(mag_mul(ai, bi)));
        u = mag_add(mag_mul(ar, bi), mag_mul(ai, br));
        t.m = round_shr(t.m, 16);
        u.m = round_shr(u.m, 16);
        r.rr = clamp32(t, sat);
        r.ri = clamp32(u, sat);
      end
      cau_pkg::OP_DIV: begin
        den = mag_mul(br, br).m + mag_mul(bi, bi).m;
        if (den == 0) dz = 1'b1;
        else begin
          t = mag_add(mag_mul(ar, br), mag_mul(ai, bi));
          u = mag_add(mag_mul(ai, br), mag_neg(mag_mul(ar, bi)));
          t.m = quot_mag(t.m, den);
          u.m = quot_mag(u.m, den);
          r.rr = clamp32(t, sat);
          r.ri = clamp32(u, sat);
        end
      end
      cau_pkg::OP_CONJ: begin
        r.rr = clamp32(of_long(ar), sat);
        r.ri = clamp32(of_long(-ai), sat);
      end
      cau_pkg::OP_MOD: begin
        t.neg = 1'b0;
        t.m = sqrt_rnd(mag_mul(ar, ar).m + mag_mul(ai, ai).m);
        r.rr = clamp32(t, sat);
      end
      cau_pkg::OP_ARG: begin
        t.neg = 1'b0;
        t.m = angle_q16(ar, ai);
        r.rr = clamp32(t, sat);
      end
      default: ;
    endcase
    r.st = dz ? cau_pkg::ST_DZ : (sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK);
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(signed'(32'($urandom_range(0, 1 << 19))) - (1 << 18));
      2: return 32'(signed'(32'($urandom_range(0, 1 << 25))) - (1 << 24));
      3: case ($urandom_range(0, 4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'd0;
           3: return 32'd1;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'(signed'(32'($urandom_range(0, 1 << 22))) - (1 << 21));
    endcase
  endfunction

  task automatic add_item(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
                          logic [31:0] br, logic [31:0] bi, bit drain = 1'b0);
    op_item_t it;
    it = '{op: op, ar: ar, ai: ai, br: br, bi: bi, drain: drain};
    pending.push_back(it);
  endtask

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("MISMATCH result %0d %s", n_checked, msg);
  endtask

  // Driver: present a new item once the last one has gone, idle now and then.
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (pending.size() == 0 || (pending[0].drain && awaited.size() != 0)) begin
        start <= 1'b0;
      end else if ((n_sent < 700 || n_sent > 1100) && $urandom_range(0, 99) < 12) begin
        start <= 1'b0;
      end else begin
        op_item_t it;
        it = pending.pop_front();
        in_operation <= it.op;
        in_a_real <= it.ar;
        in_a_imag <= it.ai;
        in_b_real <= it.br;
        in_b_imag <= it.bi;
        start <= 1'b1;
      end
    end
  end

  // Monitor: log accepted items, check strobed results, watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      cplx_res_t want;
      op_item_t it;
      taken <= start && !busy;
      if (start && !busy) begin
        it = '{op: in_operation, ar: in_a_real, ai: in_a_imag,
               br: in_b_real, bi: in_b_imag, drain: 1'b0};
        awaited.push_back(predict_result(it));
        op_count[in_operation]++;
        n_sent++;
      end
      if (out_valid) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected: %h %h %h",
                                    out_res_real, out_res_imag, out_status));
        end else begin
          want = awaited.pop_front();
          if (out_res_real !== want.rr)
            report_mismatch($sformatf("res_real: got %h expected %h",
                                      out_res_real, want.rr));
          if (out_res_imag !== want.ri)
            report_mismatch($sformatf("res_imag: got %h expected %h",
                                      out_res_imag, want.ri));
          if (out_status !== want.st)
            report_mismatch($sformatf("status: got %h expected %h",
                                      out_status, want.st));
          if (want.st == cau_pkg::ST_SAT) sat_seen++;
          if (want.st == cau_pkg::ST_DZ) dz_seen++;
        end
        n_checked++;
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIM) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIM);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    // directed corners
    add_item(cau_pkg::OP_ADD, mx, mn, mx, mn);
    add_item(cau_pkg::OP_SUB, mn, mx, mx, mn);
    add_item(cau_pkg::OP_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000,
             32'h0002_0000);
    add_item(cau_pkg::OP_MUL, mn, mn, mn, mn);
    add_item(cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000,
             32'h0000_8001);
    add_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
             32'hFFFE_0000);
    add_item(cau_pkg::OP_DIV, mx, mx, 32'd1, 32'd0);
    add_item(cau_pkg::OP_DIV, mn, mn, mn, mn);
    add_item(cau_pkg::OP_CONJ, mn, mn, mx, mx);
    add_item(cau_pkg::OP_CONJ, mx, mx, 32'd0, 32'd0);
    add_item(cau_pkg::OP_MOD, mn, mn, 32'd0, 32'd0);
    add_item(cau_pkg::OP_MOD, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, 32'd0, 32'd0, 32'd5, 32'd5);
    add_item(cau_pkg::OP_ARG, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, 32'hFFFF_0000, 32'h0001_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, 32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, mx, 32'hFFFF_FFFF, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, mn, 32'd0, 32'd0, 32'd0);
    add_item(cau_pkg::OP_ARG, 32'd0, mn, 32'd0, 32'd0);
    add_item(OP_SPARE, mx, mn, mx, mn);
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [2:0] op;
      op = $urandom_range(0, 19) == 0 ? OP_SPARE : 3'($urandom_range(0, 6));
      // hold off until the pipe is empty at two points
      add_item(op, pick_word(), pick_word(), pick_word(), pick_word(),
               i == 300 || i == 1300);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || start) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items: add %0d sub %0d mul %0d div %0d", n_sent,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("  conj %0d mod %0d arg %0d spare %0d", op_count[4], op_count[5],
             op_count[6], op_count[7]);
    $display("results checked %0d, saturated %0d, divide by zero %0d",
             n_checked, sat_seen, dz_seen);
    if (n_errors == 0 && awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
tb/complex_arithmetic_unit_top_tb.sv
